### rtl/cht_pkg.sv
// package for the chained hash table: sizes, codes and word types
`default_nettype none
package cht_pkg;
	localparam int MAX_BUCKETS = 1024;
	localparam int MAX_ENTRIES = 4096;
	localparam int KEY_WIDTH = 32;
	localparam int HANDLE_WIDTH = 32;
	localparam int BW = $clog2(MAX_BUCKETS);
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = 11;
	localparam int HW = 32;
	localparam int QDEPTH = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_MISSING = 3'd4;

	typedef struct packed {
		logic command;
		logic [KEY_WIDTH-1:0] key_value;
		logic [HW-1:0] key_hash;
		logic [HANDLE_WIDTH-1:0] node_handle;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [HANDLE_WIDTH-1:0] found_handle;
	} out_word_t;

	// classified job handed from front to back
	typedef struct packed {
		logic command;
		logic [KEY_WIDTH-1:0] key_value;
		logic [HANDLE_WIDTH-1:0] node_handle;
		logic [BW-1:0] bucket;
	} job_t;
endpackage
`default_nettype wire

### rtl/chained_hash_table_unit.sv
// top level of the chained hash table
// Each word is an insert or a lookup; one result word per input word, in order.
// The front reduces the hash modulo the clamped bucket_count one bit per cycle and
// takes no new word until it has handed the last one on; the back walks the chain,
// reading from the entry memory one entry at a time; a two-word
// queue lets the front reduce the next hash while the back walks. After reset the
// back clears the 1024 bucket lengths, one per cycle, before it takes its first
// job; words offered meanwhile wait in the front and queue.
`default_nettype none
module chained_hash_table_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cht_pkg::CW-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire cht_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output cht_pkg::out_word_t out_word
);
	import cht_pkg::*;

	logic [CW-1:0] bucket_count_q;
	logic fj_valid, fj_stall, bj_valid, bj_stall;
	job_t fj, bj;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bucket_count_q <= CW'(1024);
		else if (cfg_we) bucket_count_q <= cfg_wdata;
	end

	cht_front u_front (.clk, .arst_n, .bucket_count(bucket_count_q), .in_valid, .in_stall,
		.in_word, .job_valid(fj_valid), .job_stall(fj_stall), .job(fj));

	cht_queue u_queue (.clk, .arst_n, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_job(fj),
		.rd_valid(bj_valid), .rd_stall(bj_stall), .rd_job(bj));

	cht_back u_back (.clk, .arst_n, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
		.out_valid, .out_stall, .out_word);
endmodule
`default_nettype wire

### rtl/cht_front.sv
// front end: accepts words and reduces the hash to a bucket by restoring division
`default_nettype none
module cht_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [cht_pkg::CW-1:0] bucket_count,
	input wire logic in_valid,
	output logic in_stall,
	input wire cht_pkg::in_word_t in_word,
	output logic job_valid,
	input wire logic job_stall,
	output cht_pkg::job_t job
);
	import cht_pkg::*;

	localparam int SW = $clog2(HW + 1);

	logic busy_q, done_q;
	logic [SW-1:0] cnt_q;
	logic [HW-1:0] quo_q;
	logic [CW:0] rem_q;
	logic [CW-1:0] div_q;
	in_word_t word_q;
	logic [CW-1:0] div_eff;
	logic [CW:0] trial;

	// clamp bucket count into range
	always_comb begin
		div_eff = bucket_count;
		if (bucket_count == '0) div_eff = CW'(1);
		if (bucket_count > CW'(MAX_BUCKETS)) div_eff = CW'(MAX_BUCKETS);
	end

	assign in_stall = busy_q | done_q;
	assign trial = {rem_q[CW-1:0], quo_q[HW-1]};
	assign job_valid = done_q;
	assign job.command = word_q.command;
	assign job.key_value = word_q.key_value;
	assign job.node_handle = word_q.node_handle;
	assign job.bucket = rem_q[BW-1:0];

	// one remainder bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
				cnt_q <= SW'(HW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SW'(1);
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && !job_stall) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_q <= in_word;
			quo_q <= in_word.key_hash;
			rem_q <= '0;
			div_q <= div_eff;
		end else if (busy_q) begin
			quo_q <= {quo_q[HW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
			else rem_q <= trial;
		end
	end
endmodule
`default_nettype wire

### rtl/cht_queue.sv
// short job queue between front and back
`default_nettype none
module cht_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_stall,
	input wire cht_pkg::job_t wr_job,
	output logic rd_valid,
	input wire logic rd_stall,
	output cht_pkg::job_t rd_job
);
	import cht_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	job_t mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push, pop;

	assign wr_stall = (cnt_q == (PW+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop = rd_valid && !rd_stall;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(QDEPTH-1)) ? '0 : wp_q + PW'(1);
			if (pop) rp_q <= (rp_q == PW'(QDEPTH-1)) ? '0 : rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end
endmodule
`default_nettype wire

### rtl/cht_back.sv
// back end: walks the bucket chain in memory and inserts or reports
`default_nettype none
module cht_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_stall,
	input wire cht_pkg::job_t job,
	output logic out_valid,
	input wire logic out_stall,
	output cht_pkg::out_word_t out_word
);
	import cht_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BRD = 3'd1;
	localparam logic [2:0] S_BCHK = 3'd2;
	localparam logic [2:0] S_ERD = 3'd3;
	localparam logic [2:0] S_ECHK = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;
	localparam logic [2:0] S_CLR = 3'd7;

	// bucket lengths are cleared by a pass after reset
	logic [LW-1:0] blen_mem [MAX_BUCKETS];
	logic [EW-1:0] bhead_mem [MAX_BUCKETS];
	logic [KEY_WIDTH-1:0] ekey_mem [MAX_ENTRIES];
	logic [HANDLE_WIDTH-1:0] ehdl_mem [MAX_ENTRIES];
	logic [EW-1:0] enext_mem [MAX_ENTRIES];

	logic [2:0] state_q;
	logic [BW-1:0] clr_q;
	job_t job_q;
	logic [LW-1:0] blen_rd_q, blen_q, left_q;
	logic [EW-1:0] bhead_rd_q, idx_q;
	logic [KEY_WIDTH-1:0] ekey_rd_q;
	logic [HANDLE_WIDTH-1:0] ehdl_rd_q;
	logic [EW-1:0] enext_rd_q;
	logic [LW-1:0] used_q;
	logic hit_q;
	logic wr_en;
	logic blen_we;
	logic [BW-1:0] blen_wa;
	logic [LW-1:0] blen_wd;
	out_word_t res_q;

	assign job_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_word = res_q;
	assign wr_en = (state_q == S_DONE) && !hit_q && job_q.command == CMD_INSERT
		&& used_q < LW'(MAX_ENTRIES);

	// bucket length write port: clearing pass or insert
	always_comb begin
		blen_we = wr_en;
		blen_wa = job_q.bucket;
		blen_wd = blen_q + LW'(1);
		if (state_q == S_CLR) begin
			blen_we = 1'b1;
			blen_wa = clr_q;
			blen_wd = '0;
		end
	end

	// memory reads and writes
	always_ff @(posedge clk) begin
		blen_rd_q <= blen_mem[job_q.bucket];
		bhead_rd_q <= bhead_mem[job_q.bucket];
		ekey_rd_q <= ekey_mem[idx_q];
		ehdl_rd_q <= ehdl_mem[idx_q];
		enext_rd_q <= enext_mem[idx_q];
		if (blen_we) blen_mem[blen_wa] <= blen_wd;
		if (wr_en) begin
			bhead_mem[job_q.bucket] <= used_q[EW-1:0];
			ekey_mem[used_q[EW-1:0]] <= job_q.key_value;
			ehdl_mem[used_q[EW-1:0]] <= job_q.node_handle;
			enext_mem[used_q[EW-1:0]] <= (blen_q != '0) ? bhead_rd_q : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			used_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(MAX_BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (job_valid) state_q <= S_BRD;
				S_BRD: state_q <= S_BCHK;
				S_BCHK: begin
					if (blen_rd_q == '0) state_q <= S_DONE;
					else state_q <= S_ERD;
				end
				S_ERD: state_q <= S_ECHK;
				S_ECHK: begin
					if (ekey_rd_q == job_q.key_value || left_q == LW'(1)) state_q <= S_DONE;
					else state_q <= S_ERD;
				end
				S_DONE: begin
					state_q <= S_OUT;
					if (wr_en) used_q <= used_q + LW'(1);
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (job_valid) job_q <= job;
			S_BCHK: begin
				blen_q <= blen_rd_q;
				left_q <= blen_rd_q;
				idx_q <= bhead_rd_q;
				hit_q <= 1'b0;
			end
			S_ECHK: begin
				if (ekey_rd_q == job_q.key_value) begin
					hit_q <= 1'b1;
					res_q.found_handle <= ehdl_rd_q;
				end else if (left_q != LW'(1)) begin
					idx_q <= enext_rd_q;
					left_q <= left_q - LW'(1);
				end
			end
			S_DONE: begin
				if (job_q.command == CMD_LOOKUP) begin
					res_q.status <= hit_q ? ST_FOUND : ST_MISSING;
					if (!hit_q) res_q.found_handle <= '0;
				end else begin
					res_q.found_handle <= '0;
					if (hit_q) res_q.status <= ST_DUPLICATE;
					else if (used_q >= LW'(MAX_ENTRIES)) res_q.status <= ST_FULL;
					else res_q.status <= ST_INSERTED;
				end
				idx_q <= bhead_rd_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
